FILE: rtl/afq_pkg.sv
// Package: constants, types and helper functions for the advertisement filter queue.
`default_nettype none

package afq_pkg;

  // Command codes carried by the command field of an input item.
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // Field widths.
  localparam int BYTE_W  = 8;
  localparam int POS_W   = 5;
  localparam int TYPE_W  = 3;
  localparam int FP_W    = 16;
  localparam int ENTRY_W = TYPE_W + FP_W;
  localparam int CHAR_W  = 7;
  localparam int COUNT_W = 32;

  // Payload layout: byte positions within one advertisement.
  localparam logic [POS_W-1:0] POS_HDR0    = 5'd0;
  localparam logic [POS_W-1:0] POS_HDR1    = 5'd1;
  localparam logic [POS_W-1:0] POS_TYPE    = 5'd2;
  localparam logic [POS_W-1:0] POS_FP_HIGH = 5'd15;
  localparam logic [POS_W-1:0] POS_FINAL   = 5'd16;
  localparam logic [POS_W-1:0] POS_MAX     = 5'd31;

  // Header values.
  localparam logic [BYTE_W-1:0] HDR_BYTE = 8'hFF;
  localparam logic [BYTE_W-1:0] TYPE_MIN = 8'h01;
  localparam logic [BYTE_W-1:0] TYPE_MAX = 8'h05;

  // ASCII codes for hex digits.
  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 7'd48;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'd97;
  localparam logic [3:0]        NIB_TEN      = 4'd10;

  // One queued entry: message type and fingerprint.
  typedef struct packed {
    logic [TYPE_W-1:0] msg_type;
    logic [FP_W-1:0]   fingerprint;
  } entry_t;

  // Lowercase ASCII hex character of one nibble.
  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
    logic [CHAR_W-1:0] c;
    if (nib < NIB_TEN) begin
      c = CHAR_ZERO + CHAR_W'(nib);
    end else begin
      c = CHAR_LOWER_A + CHAR_W'(nib - NIB_TEN);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/advert_filter_queue.sv
// Top level: advertisement payload filter with a fingerprint ring queue.
`default_nettype none

// The block takes one item per cycle: either a payload byte or a pop command.
// Payload bytes are checked on the fly (length 17, two 0xFF header bytes,
// type 1 to 5), and an accepted payload writes its type and fingerprint into
// a ring of RING_SLOTS slots in a RAM, which holds at most RING_SLOTS-1
// entries; a payload that arrives while the ring is full is dropped. Only a
// pop yields a result item: it passes through the registered RAM read into
// the read stage and then into the output register, which formats it.
// Payload bytes never produce a result. The input side takes a new item in
// every cycle unless a pop result is waiting in the read stage while the
// output register is still held by out_ready. The ring needs no clearing
// after reset.

module advert_filter_queue #(
  parameter int RING_SLOTS = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          command,
  input  wire logic [afq_pkg::BYTE_W-1:0]    data_byte,
  input  wire logic                          last_byte,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               entry_valid,
  output logic      [afq_pkg::CHAR_W-1:0]    hex_char_0,
  output logic      [afq_pkg::CHAR_W-1:0]    hex_char_1,
  output logic      [afq_pkg::CHAR_W-1:0]    hex_char_2,
  output logic      [afq_pkg::CHAR_W-1:0]    hex_char_3,
  output logic      [afq_pkg::TYPE_W-1:0]    message_type,
  output logic      [afq_pkg::COUNT_W-1:0]   delivered_count
);

  import afq_pkg::*;

  localparam int PTR_W = $clog2(RING_SLOTS);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_SLOTS - 1);

  // Parser state.
  logic [POS_W-1:0]  byte_position;
  logic              header_bad;
  logic [TYPE_W-1:0] captured_type;
  logic [BYTE_W-1:0] captured_fp_high;

  // Ring pointers and delivered total.
  logic [PTR_W-1:0]   write_pointer;
  logic [PTR_W-1:0]   read_pointer;
  logic [COUNT_W-1:0] pop_total;

  // Read stage (RAM data valid) and its side information.
  logic               s1_valid;
  logic               s1_hit;
  logic [COUNT_W-1:0] s1_count;

  entry_t             ram_wdata;
  entry_t             ram_rdata;
  logic [ENTRY_W-1:0] ram_rdata_raw;

  logic               in_acc;
  logic               byte_acc;
  logic               pop_acc;
  logic               out_free;
  logic               s1_adv;
  logic               ring_empty;
  logic [PTR_W-1:0]   write_pointer_next;
  logic [PTR_W-1:0]   read_pointer_next;
  logic               ring_full;
  logic               payload_ok;
  logic               ring_we;
  logic               byte_hdr_bad;
  logic [COUNT_W-1:0] pop_total_next;

  // Handshake decode.
  assign out_free = !out_valid || out_ready;
  assign s1_adv   = s1_valid && out_free;
  assign in_ready = !s1_valid || out_free;
  assign in_acc   = in_valid && in_ready;
  assign byte_acc = in_acc && (command == CMD_BYTE);
  assign pop_acc  = in_acc && (command == CMD_POP);

  // Ring pointer arithmetic, wrapping at RING_SLOTS.
  assign write_pointer_next = (write_pointer == PTR_LAST) ? '0 : write_pointer + 1'b1;
  assign read_pointer_next  = (read_pointer == PTR_LAST) ? '0 : read_pointer + 1'b1;
  assign ring_full          = (write_pointer_next == read_pointer);
  assign ring_empty         = (write_pointer == read_pointer);
  assign pop_total_next     = pop_total + 1'b1;

  // Header check of the current byte.
  always_comb begin
    byte_hdr_bad = 1'b0;
    if (byte_position == POS_HDR0 || byte_position == POS_HDR1) begin
      byte_hdr_bad = (data_byte != HDR_BYTE);
    end else if (byte_position == POS_TYPE) begin
      byte_hdr_bad = (data_byte < TYPE_MIN) || (data_byte > TYPE_MAX);
    end
  end

  // A payload is taken when its last byte lands on the final position with a clean header.
  assign payload_ok = last_byte && (byte_position == POS_FINAL) && !header_bad;
  assign ring_we    = byte_acc && payload_ok && !ring_full;

  assign ram_wdata.msg_type    = captured_type;
  assign ram_wdata.fingerprint = {captured_fp_high, data_byte};

  afq_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(RING_SLOTS)
  ) u_ring (
    .clk  (clk),
    .we   (ring_we),
    .waddr(write_pointer),
    .wdata(ram_wdata),
    .re   (pop_acc),
    .raddr(read_pointer),
    .rdata(ram_rdata_raw)
  );

  assign ram_rdata = entry_t'(ram_rdata_raw);

  // Parser registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= '0;
      header_bad       <= 1'b0;
      captured_type    <= '0;
      captured_fp_high <= '0;
    end else if (byte_acc) begin
      if (byte_position == POS_TYPE) begin
        captured_type <= data_byte[TYPE_W-1:0];
      end
      if (byte_position == POS_FP_HIGH) begin
        captured_fp_high <= data_byte;
      end
      if (last_byte) begin
        byte_position <= '0;
        header_bad    <= 1'b0;
      end else begin
        header_bad <= header_bad | byte_hdr_bad;
        if (byte_position != POS_MAX) begin
          byte_position <= byte_position + 1'b1;
        end
      end
    end
  end

  // Ring pointers and delivered total.
  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer <= '0;
      read_pointer  <= '0;
      pop_total     <= '0;
    end else begin
      if (ring_we) begin
        write_pointer <= write_pointer_next;
      end
      if (pop_acc && !ring_empty) begin
        read_pointer <= read_pointer_next;
        pop_total    <= pop_total_next;
      end
    end
  end

  // Read stage: waits for the RAM data of an accepted pop.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pop_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_acc) begin
      s1_hit   <= !ring_empty;
      s1_count <= ring_empty ? pop_total : pop_total_next;
    end
  end

  // Output register: formats the popped entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      entry_valid     <= s1_hit;
      delivered_count <= s1_count;
      if (s1_hit) begin
        hex_char_0   <= hex_char(ram_rdata.fingerprint[15:12]);
        hex_char_1   <= hex_char(ram_rdata.fingerprint[11:8]);
        hex_char_2   <= hex_char(ram_rdata.fingerprint[7:4]);
        hex_char_3   <= hex_char(ram_rdata.fingerprint[3:0]);
        message_type <= ram_rdata.msg_type;
      end else begin
        hex_char_0   <= CHAR_ZERO;
        hex_char_1   <= CHAR_ZERO;
        hex_char_2   <= CHAR_ZERO;
        hex_char_3   <= CHAR_ZERO;
        message_type <= '0;
      end
    end
  end

  // A waiting read stage behind a held output register must stop the input side.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while the read stage is blocked");

  // A pop on an empty ring leaves the delivered total alone.
  a_empty_pop_count: assert property (@(posedge clk) disable iff (rst)
    (pop_acc && ring_empty) |=> $stable(pop_total))
    else $error("delivered total moved on an empty pop");

  // An accepted pop always fills the read stage in the next cycle.
  a_pop_fills_stage: assert property (@(posedge clk) disable iff (rst)
    pop_acc |=> s1_valid)
    else $error("accepted pop did not reach the read stage");

  // A delivered entry always carries a legal message type.
  a_entry_type_legal: assert property (@(posedge clk) disable iff (rst)
    (out_valid && entry_valid) |->
      (message_type >= TYPE_W'(TYPE_MIN) && message_type <= TYPE_W'(TYPE_MAX)))
    else $error("delivered entry has an illegal message type");

  // The ring never writes while full.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ring_we |-> !ring_full)
    else $error("ring written while full");

endmodule

`default_nettype wire

FILE: rtl/afq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module afq_ram #(
  parameter int WIDTH = 19,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
